// ===== sv/integer_stack_machine_macros.svh =====
// Assertion helpers for integer_stack_machine.sv, which checks internal behavior.
`ifndef INTEGER_STACK_MACHINE_MACROS_SVH
`define INTEGER_STACK_MACHINE_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define ISM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define ISM_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

// ===== sv/ism_pkg.sv =====
`default_nettype none

package ism_pkg;

  localparam int unsigned WordW      = 32;
  localparam int unsigned ActionW    = 4;
  localparam int unsigned DepthW     = 7;
  localparam int unsigned StackDepth = 64;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [ActionW-1:0] {
    ACT_CONST = 4'd0,
    ACT_ADD   = 4'd1,
    ACT_SUB   = 4'd2,
    ACT_MUL   = 4'd3,
    ACT_DIV   = 4'd4,
    ACT_MAX   = 4'd5,
    ACT_MIN   = 4'd6,
    ACT_NEG   = 4'd7,
    ACT_DUP   = 4'd8,
    ACT_SWAP  = 4'd9,
    ACT_END   = 4'd10,
    ACT_NOP   = 4'd11
  } action_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_UNDER   = 2'd1,
    ST_OVER    = 2'd2,
    ST_DIVZERO = 2'd3
  } status_e;

  typedef struct packed {
    action_e            op;
    logic [WordW-1:0]   operand;
  } cmd_t;

endpackage

`default_nettype wire

// ===== sv/integer_stack_machine.sv =====
// Results: the output register loads when a transaction is accepted, for DIV when the
// divider finishes. CONST, NEG, DUP, SWAP and no-ops finish in EXEC; binary operators and
// END also pass LOAD (refill of the second word from stack memory); DIV passes issue, 32
// divider steps plus the done strobe, and the refill. A 2-entry queue keeps taking input
// while the back stalls. Reset: asynchronous, active low; clears stack pointer, queue and
// control state. The stack memory is not cleared and needs no clearing pass.
`default_nettype none
`include "integer_stack_machine_macros.svh"

module integer_stack_machine #(
  parameter int unsigned STACK_DEPTH = ism_pkg::StackDepth
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [ism_pkg::ActionW-1:0]        action_i,
  input  logic signed [ism_pkg::WordW-1:0]   operand_value_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [ism_pkg::WordW-1:0]   top_value_o,
  output logic [ism_pkg::DepthW-1:0]         stack_depth_o,
  output logic [1:0]                         status_o,
  output logic                               final_result_o
);
  import ism_pkg::*;

  localparam logic [DepthW-1:0] FullDepth = DepthW'(STACK_DEPTH);

  // Queue handshake between the front (accept and classify) and the back (execute).
  logic    q_valid, q_ready;
  cmd_t    q_cmd;
  status_e back_status;
  logic    over_seen, under_seen;

  ism_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .action_i        (action_i),
    .operand_value_i (operand_value_i),
    .q_valid_o       (q_valid),
    .q_ready_i       (q_ready),
    .cmd_o           (q_cmd)
  );

  // Hold the top two words in registers, the rest in memory; drop to the
  // divider for DIV and refill the second word after every pop.
  ism_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_ready_o      (q_ready),
    .cmd_i          (q_cmd),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .top_value_o    (top_value_o),
    .stack_depth_o  (stack_depth_o),
    .status_o       (back_status),
    .final_result_o (final_result_o)
  );

  assign status_o = back_status;

  assign over_seen  = out_valid_o && (status_o == ST_OVER);
  assign under_seen = out_valid_o && (status_o == ST_UNDER);

  // Never pop an empty queue.
  `ISM_ASSERT_NEVER(a_pop_empty, q_ready && !q_valid, "queue popped while empty")
  // Overflow is reported only on a full stack.
  `ISM_ASSERT(a_over_full, over_seen |-> stack_depth_o == FullDepth, "overflow below full depth")
  // Underflow is reported only with fewer than two words.
  `ISM_ASSERT(a_under_low, under_seen |-> stack_depth_o <= DepthW'(1), "underflow with deep stack")

endmodule

`default_nettype wire

// ===== sv/ism_div.sv =====
`default_nettype none

module ism_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [ism_pkg::WordW-1:0]  dividend_i,
  input  logic [ism_pkg::WordW-1:0]  divisor_i,
  output logic                       done_o,
  output logic [ism_pkg::WordW-1:0]  quotient_o
);
  import ism_pkg::*;

  localparam int unsigned CntW = $clog2(WordW);

  logic             busy_q, done_q, neg_q;
  logic [CntW-1:0]  cnt_q;
  logic [WordW-1:0] rem_q, quo_q, dvs_q;
  logic [WordW:0]   shifted, diff;

  // One quotient bit per cycle, restoring division on magnitudes.
  assign shifted = {rem_q, quo_q[WordW-1]};
  assign diff    = shifted - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CntW'(1);
      if (cnt_q == CntW'(WordW - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i[WordW-1] ? (WordW'(0) - dividend_i) : dividend_i;
      dvs_q <= divisor_i[WordW-1] ? (WordW'(0) - divisor_i) : divisor_i;
      neg_q <= dividend_i[WordW-1] ^ divisor_i[WordW-1];
    end else if (busy_q) begin
      if (!diff[WordW]) begin
        rem_q <= diff[WordW-1:0];
        quo_q <= {quo_q[WordW-2:0], 1'b1};
      end else begin
        rem_q <= shifted[WordW-1:0];
        quo_q <= {quo_q[WordW-2:0], 1'b0};
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? (WordW'(0) - quo_q) : quo_q;

endmodule

`default_nettype wire

// ===== sv/ism_front.sv =====
`default_nettype none

module ism_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [ism_pkg::ActionW-1:0] action_i,
  input  logic [ism_pkg::WordW-1:0]   operand_value_i,
  output logic                        q_valid_o,
  input  logic                        q_ready_i,
  output ism_pkg::cmd_t               cmd_o
);
  import ism_pkg::*;

  localparam int unsigned QAW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QCW = $clog2(QueueDepth + 1);

  cmd_t           queue_q [QueueDepth];
  logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCW-1:0] count_q;
  logic           push, pop;
  cmd_t           cmd_dec;

  // Classify: unused action codes become a no-op.
  always_comb begin
    cmd_dec.operand = operand_value_i;
    if (action_i > ACT_END) begin
      cmd_dec.op = ACT_NOP;
    end else begin
      cmd_dec.op = action_e'(action_i);
    end
  end

  assign in_ready_o = (count_q != QCW'(QueueDepth));
  assign q_valid_o  = (count_q != '0);
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_ready_i && q_valid_o;
  assign cmd_o      = queue_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QAW'(QueueDepth - 1)) ? '0 : wr_ptr_q + QAW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QAW'(QueueDepth - 1)) ? '0 : rd_ptr_q + QAW'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + QCW'(1);
      end else if (pop && !push) begin
        count_q <= count_q - QCW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd_dec;
    end
  end

endmodule

`default_nettype wire

// ===== sv/ism_back.sv =====
`default_nettype none

module ism_back #(
  parameter int unsigned STACK_DEPTH = ism_pkg::StackDepth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_valid_i,
  output logic                       q_ready_o,
  input  ism_pkg::cmd_t              cmd_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [ism_pkg::WordW-1:0]  top_value_o,
  output logic [ism_pkg::DepthW-1:0] stack_depth_o,
  output ism_pkg::status_e           status_o,
  output logic                       final_result_o
);
  import ism_pkg::*;

  localparam int unsigned AW  = $clog2(STACK_DEPTH);
  localparam int unsigned SpW = $clog2(STACK_DEPTH + 1);

  localparam logic [1:0] S_EXEC = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_LOAD = 2'd2;

  // Top two words live in registers; the rest of the stack sits in memory.
  logic [WordW-1:0] mem_q [STACK_DEPTH];
  logic [WordW-1:0] rd_q;

  logic [1:0]       state_q, state_d;
  logic [SpW-1:0]   sp_q, sp_d, sp_m2, sp_m3;
  logic [WordW-1:0] top_q, top_d, sec_q, sec_d;
  logic             has_one, has_two, has_three, full;
  logic             wr_en, rd_en, div_start, div_done, can_issue;
  logic [WordW-1:0] alu_res, quotient, res_top;
  logic             out_load, end_pop, res_final;
  status_e          res_status;

  logic             out_valid_q, out_final_q;
  logic [WordW-1:0] out_top_q;
  logic [DepthW-1:0] out_depth_q;
  status_e          out_status_q;

  assign sp_m2     = sp_q - SpW'(2);
  assign sp_m3     = sp_q - SpW'(3);
  assign has_one   = (sp_q != '0);
  assign has_two   = (sp_q >= SpW'(2));
  assign has_three = (sp_q >= SpW'(3));
  assign full      = (sp_q == SpW'(STACK_DEPTH));
  assign can_issue = !out_valid_q || out_ready_i;

  ism_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (top_q),
    .divisor_i  (sec_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_comb begin
    unique case (cmd_i.op)
      ACT_ADD: alu_res = top_q + sec_q;
      ACT_SUB: alu_res = top_q - sec_q;
      ACT_MUL: alu_res = top_q * sec_q;
      ACT_MAX: alu_res = ($signed(top_q) > $signed(sec_q)) ? top_q : sec_q;
      default: alu_res = ($signed(sec_q) > $signed(top_q)) ? top_q : sec_q;
    endcase
  end

  always_comb begin
    state_d    = state_q;
    sp_d       = sp_q;
    top_d      = top_q;
    sec_d      = sec_q;
    q_ready_o  = 1'b0;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    end_pop    = 1'b0;
    res_final  = 1'b0;
    res_status = ST_OK;
    unique case (state_q)
      S_EXEC: begin
        if (q_valid_i && can_issue) begin
          q_ready_o = 1'b1;
          out_load  = 1'b1;
          unique case (cmd_i.op)
            ACT_CONST, ACT_DUP: begin
              if (cmd_i.op == ACT_DUP && !has_one) begin
                res_status = ST_UNDER;
              end else if (full) begin
                res_status = ST_OVER;
              end else begin
                wr_en = has_two;
                top_d = (cmd_i.op == ACT_CONST) ? cmd_i.operand : top_q;
                sec_d = top_q;
                sp_d  = sp_q + SpW'(1);
              end
            end
            ACT_ADD, ACT_SUB, ACT_MUL, ACT_MAX, ACT_MIN: begin
              if (!has_two) begin
                res_status = ST_UNDER;
              end else begin
                top_d   = alu_res;
                sp_d    = sp_q - SpW'(1);
                rd_en   = has_three;
                state_d = S_LOAD;
              end
            end
            ACT_DIV: begin
              if (!has_two) begin
                res_status = ST_UNDER;
              end else if (sec_q == '0) begin
                res_status = ST_DIVZERO;
              end else begin
                out_load  = 1'b0;
                div_start = 1'b1;
                state_d   = S_DIV;
              end
            end
            ACT_NEG: begin
              if (!has_one) begin
                res_status = ST_UNDER;
              end else begin
                top_d = WordW'(0) - top_q;
              end
            end
            ACT_SWAP: begin
              if (!has_two) begin
                res_status = ST_UNDER;
              end else begin
                top_d = sec_q;
                sec_d = top_q;
              end
            end
            ACT_END: begin
              res_final = 1'b1;
              if (!has_one) begin
                res_status = ST_UNDER;
              end else begin
                end_pop = 1'b1;
                top_d   = sec_q;
                sp_d    = sp_q - SpW'(1);
                rd_en   = has_three;
                state_d = S_LOAD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_DIV: begin
        // Output register is free here: it was free when the divide issued.
        if (div_done) begin
          top_d    = quotient;
          sp_d     = sp_q - SpW'(1);
          rd_en    = has_three;
          out_load = 1'b1;
          state_d  = S_LOAD;
        end
      end
      S_LOAD: begin
        sec_d   = rd_q;
        state_d = S_EXEC;
      end
      default: state_d = S_EXEC;
    endcase
  end

  assign res_top = end_pop ? top_q : ((sp_d != '0) ? top_d : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_EXEC;
      sp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      sp_q    <= sp_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
    sec_q <= sec_d;
    if (out_load) begin
      out_top_q    <= res_top;
      out_depth_q  <= DepthW'(sp_d);
      out_status_q <= res_status;
      out_final_q  <= res_final;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[sp_m2[AW-1:0]] <= sec_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= mem_q[sp_m3[AW-1:0]];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign top_value_o    = out_top_q;
  assign stack_depth_o  = out_depth_q;
  assign status_o       = out_status_q;
  assign final_result_o = out_final_q;

endmodule

`default_nettype wire
